// ===== rtl/isr_pkg.sv =====
// Shared constants and a width helper for the integer square root unit.
// Used by isr_cell and integer_square_root_unit; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package isr_pkg;

  // Default radicand width and the fixed width of the reported root field.
  localparam int DEF_INPUT_WIDTH  = 32;
  localparam int ROOT_FIELD_WIDTH = 16;

  // Number of root bits, one per pair of radicand bits.
  function automatic int root_width(input int w);
    return (w + 1) >>> 1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/isr_cell.sv =====
// One cell of the square root chain: a single restoring shift-and-subtract step.
// Depends on isr_pkg for the root width helper.
`timescale 1ns / 1ps
`default_nettype none

module isr_cell #(
  parameter int  INPUT_WIDTH = isr_pkg::DEF_INPUT_WIDTH,
  localparam int RW          = isr_pkg::root_width(INPUT_WIDTH),
  localparam int PW          = 2 * RW,
  localparam int RMW         = RW + 2
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           advance,
  input  wire logic           prev_valid,
  input  wire logic [PW-1:0]  prev_rad,
  input  wire logic [RMW-1:0] prev_rem,
  input  wire logic [RW-1:0]  prev_root,
  output logic                valid,
  output logic [PW-1:0]       rad,
  output logic [RMW-1:0]      rem,
  output logic [RW-1:0]       root
);

  logic [RMW-1:0] shifted;
  logic [RMW-1:0] trial;
  logic [RMW-1:0] diff;
  logic           ge;

  // The top two remainder bits are always zero ahead of any step that can
  // still set a root bit, so dropping them loses nothing.
  always_comb begin
    shifted = {prev_rem[RW-1:0], prev_rad[PW-1 -: 2]};
    trial   = {prev_root, 2'b01};
    diff    = shifted - trial;
    ge      = (shifted >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rad  <= prev_rad << 2;
      rem  <= ge ? diff : shifted;
      root <= RW'({prev_root, ge});
    end
  end

endmodule

`default_nettype wire

// ===== rtl/integer_square_root_unit.sv =====
// Integer square root unit: floor root of an unsigned radicand.
// Each word passes through the cells of the chain and then the output register before out_valid.
// Throughput: one word per cycle; each cell of the chain settles one root bit.
// The chain advances only when the output register is empty or being taken.
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
// Depends on isr_pkg and isr_cell.
`timescale 1ns / 1ps
`default_nettype none

module integer_square_root_unit #(
  parameter int INPUT_WIDTH = isr_pkg::DEF_INPUT_WIDTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [INPUT_WIDTH-1:0]               radicand,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [isr_pkg::ROOT_FIELD_WIDTH-1:0]      root
);

  localparam int RW  = isr_pkg::root_width(INPUT_WIDTH);
  localparam int PW  = 2 * RW;
  localparam int RMW = RW + 2;
  localparam int RFW = isr_pkg::ROOT_FIELD_WIDTH;

  logic            advance;
  logic            valid_chain [0:RW];
  logic [PW-1:0]   rad_chain   [0:RW];
  logic [RMW-1:0]  rem_chain   [0:RW];
  logic [RW-1:0]   root_chain  [0:RW];

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // The head of the chain takes the word straight from the input port.
  assign valid_chain[0] = in_valid;
  assign rad_chain[0]   = PW'(radicand);
  assign rem_chain[0]   = '0;
  assign root_chain[0]  = '0;

  for (genvar i = 0; i < RW; i++) begin : g_cell
    isr_cell #(
      .INPUT_WIDTH(INPUT_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .prev_valid(valid_chain[i]),
      .prev_rad  (rad_chain[i]),
      .prev_rem  (rem_chain[i]),
      .prev_root (root_chain[i]),
      .valid     (valid_chain[i+1]),
      .rad       (rad_chain[i+1]),
      .rem       (rem_chain[i+1]),
      .root      (root_chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= valid_chain[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      root <= RFW'(root_chain[RW]);
    end
  end

`ifndef SYNTH
  // A finished root always leaves a remainder no larger than twice itself.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    valid_chain[RW] |-> (rem_chain[RW] <= {root_chain[RW], 1'b0}))
    else $error("remainder exceeds twice the root at chain end");

  // A word leaving the chain lands in the output register.
  a_chain_to_out: assert property (@(posedge clk) disable iff (rst)
    advance && valid_chain[RW] |=> out_valid)
    else $error("word at chain end was dropped");

  // While stalled, the word at the end of the chain must not move.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(valid_chain[RW]) && $stable(root_chain[RW]))
    else $error("chain moved during a stall");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !valid_chain[RW])
    else $error("valid bits not cleared by reset");
`endif

endmodule

`default_nettype wire
